// ===== design/caldc_pkg.sv =====
// Shared types, codes and calendar helper functions for the calendar date counter.
// No dependencies; imported by every module of the block.
package caldc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int MODE_W  = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

    localparam logic [WDAY_W-1:0] WDAY_SUN = 3'd0;
    localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

    localparam logic [YEAR_W-1:0] RESET_YEAR = 14'd2000;

    // n is a multiple of 25 iff (n * inv25) mod 2^14 <= floor((2^14-1)/25)
    localparam logic [YEAR_W-1:0] DIV25_INV = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

    // floor(y/100) = (y * 5243) >> 19 for any 14-bit y
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP100_SH = 19;
    // floor(s/7) = (s * 37450) >> 18 for any s below 2^15
    localparam logic [15:0] RECIP7      = 16'd37450;
    localparam int          RECIP7_SH   = 18;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic               rejected;
        logic               december;
        logic               month_end;
        logic               weekend;
        logic [WDAY_W-1:0]  weekday;
        t_date              date;
    } t_result;

    // Leap year: divisible by 4, and either not by 25 or also by 16.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] low;
        logic              div25;
        low   = y * DIV25_INV;
        div25 = (low <= DIV25_LIM);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * mm) / 12 for the March-based month number mm
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] mm);
        logic [DAY_W-1:0] off;
        case (mm)
            4'd1:    off = 5'd2;
            4'd2:    off = 5'd5;
            4'd3:    off = 5'd7;
            4'd4:    off = 5'd10;
            4'd5:    off = 5'd12;
            4'd6:    off = 5'd15;
            4'd7:    off = 5'd18;
            4'd8:    off = 5'd20;
            4'd9:    off = 5'd23;
            4'd10:   off = 5'd25;
            4'd11:   off = 5'd28;
            4'd12:   off = 5'd31;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== design/calendar_date_counter.sv =====
// Calendar date counter top level: request register, date state, weekday pipeline.
// Depends on caldc_pkg, caldc_date_step and caldc_weekday.
//
// Keeps one proleptic Gregorian date, reset to Saturday 1 January 2000. Each
// request steps the date forward a day (mode 0), back a day (mode 1), loads a
// date (mode 2) or holds it (mode 3), and returns exactly one result: the new
// date, its weekday (0 Sunday .. 6 Saturday), and weekend, last-day-of-month,
// December and rejected flags. A load with a year outside 1..YEAR_MAX, a month
// outside 1..12 or a day outside 1..that month's length is refused; stepping past
// 31 December YEAR_MAX or before 1 January of year 1 holds the date. Either
// case keeps the date and raises rejected. One request is taken every clock
// while the result is not stalled; it passes the request register and the date
// step register, then the weekday formula in three registered stages (century
// count, weekday sum, mod 7). The date update is combinational around the date
// state register, so nothing feeds back from the weekday side. All stages advance
// together: a stalled result holds the pipe, and the upstream tready follows it.
module calendar_date_counter import caldc_pkg::*; #(
    parameter int YEAR_MAX = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // load_year[13:0], load_month[17:14], load_day[22:18], 0
    input  logic [1:0]  i_s_axis_tuser,  // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // year[13:0], month[17:14], day[22:18], weekday[25:23],
                                         // weekend[26], month_end[27], december[28],
                                         // rejected[29], 0
);

    logic              advance;
    logic              r_in_valid;
    logic [MODE_W-1:0] r_in_mode;
    t_date             r_in_load;

    logic              step_valid;
    t_date             step_date;
    logic              step_rej;
    logic              res_valid;
    t_result           res;

    // The whole pipe moves when the result register is empty or being drained.
    assign advance         = !res_valid || i_m_axis_tready;
    assign o_s_axis_tready = advance;

    // Request register: capture mode and load fields on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_s_axis_tvalid) begin
            r_in_mode       <= i_s_axis_tuser;
            r_in_load.year  <= i_s_axis_tdata[13:0];
            r_in_load.month <= i_s_axis_tdata[17:14];
            r_in_load.day   <= i_s_axis_tdata[22:18];
        end
    end

    // Date state and its update.
    caldc_date_step #(
        .YEAR_MAX (YEAR_MAX)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (r_in_valid),
        .i_mode  (r_in_mode),
        .i_load  (r_in_load),
        .o_valid (step_valid),
        .o_date  (step_date),
        .o_rej   (step_rej)
    );

    // Weekday and flags, ending in the result register.
    caldc_weekday u_wday (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_valid  (step_valid),
        .i_date   (step_date),
        .i_rej    (step_rej),
        .o_valid  (res_valid),
        .o_result (res)
    );

    assign o_m_axis_tvalid = res_valid;
    assign o_m_axis_tdata  = {2'b00, res.rejected, res.december, res.month_end, res.weekend,
                              res.weekday, res.date.day, res.date.month, res.date.year};

    // Every delivered date has a month in 1..12, a day of at least 1 and a nonzero year.
    a_date_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res.date.month >= MONTH_JAN) && (res.date.month <= MONTH_DEC)
                   && (res.date.day >= DAY_FIRST) && (res.date.year != 14'd0))
        else $error("result date out of range");

    // The mod-7 reduction never leaves a remainder of seven.
    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res.weekday <= WDAY_SAT))
        else $error("weekday out of range");

    // Last day of a month is never before the 28th.
    a_month_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.month_end) |-> (res.date.day >= 5'd28))
        else $error("month end flagged on an early day");

endmodule

// ===== design/caldc_date_step.sv =====
// Date state register and its combinational update (step forward, step back, load, hold).
// Depends on caldc_pkg.
module caldc_date_step import caldc_pkg::*; #(
    parameter int YEAR_MAX = 9999
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [MODE_W-1:0]   i_mode,
    input  t_date               i_load,
    output logic                o_valid,
    output t_date               o_date,
    output logic                o_rej
);

    localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_MAX);
    localparam logic [YEAR_W-1:0] YMIN = 14'd1;

    t_date            r_date;
    t_date            r_out_date;
    logic             r_valid;
    logic             r_rej;
    t_date            n_date;
    logic             n_rej;
    logic             leap_cur;
    logic             leap_ld;
    logic [DAY_W-1:0] dim_cur;
    logic [DAY_W-1:0] dim_prev;
    logic [DAY_W-1:0] dim_ld;
    logic             load_ok;

    always_comb begin
        leap_cur = is_leap(r_date.year);
        dim_cur  = days_in(leap_cur, r_date.month);
        dim_prev = days_in(leap_cur, r_date.month - 4'd1);
        leap_ld  = is_leap(i_load.year);
        dim_ld   = days_in(leap_ld, i_load.month);
        load_ok  = (i_load.year >= YMIN) && (i_load.year <= YMAX)
                && (i_load.month >= MONTH_JAN) && (i_load.month <= MONTH_DEC)
                && (i_load.day >= DAY_FIRST) && (i_load.day <= dim_ld);

        n_date = r_date;
        n_rej  = 1'b0;
        case (i_mode)
            MODE_FWD: begin
                if (r_date.day < dim_cur) begin
                    n_date.day = r_date.day + 5'd1;
                end else if (r_date.month < MONTH_DEC) begin
                    n_date.day   = DAY_FIRST;
                    n_date.month = r_date.month + 4'd1;
                end else if (r_date.year >= YMAX) begin
                    n_rej = 1'b1;
                end else begin
                    n_date.day   = DAY_FIRST;
                    n_date.month = MONTH_JAN;
                    n_date.year  = r_date.year + 14'd1;
                end
            end
            MODE_BACK: begin
                if (r_date.day > DAY_FIRST) begin
                    n_date.day = r_date.day - 5'd1;
                end else if (r_date.month > MONTH_JAN) begin
                    n_date.month = r_date.month - 4'd1;
                    n_date.day   = dim_prev;
                end else if (r_date.year <= YMIN) begin
                    n_rej = 1'b1;
                end else begin
                    n_date.year  = r_date.year - 14'd1;
                    n_date.month = MONTH_DEC;
                    n_date.day   = DAY_LAST_DEC;
                end
            end
            MODE_LOAD: begin
                if (load_ok) begin
                    n_date = i_load;
                end else begin
                    n_rej = 1'b1;
                end
            end
            default: begin
                n_date = r_date;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date.year  <= RESET_YEAR;
            r_date.month <= MONTH_JAN;
            r_date.day   <= DAY_FIRST;
            r_valid      <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_date <= n_date;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_out_date <= n_date;
            r_rej      <= n_rej;
        end
    end

    assign o_valid = r_valid;
    assign o_date  = r_out_date;
    assign o_rej   = r_rej;

endmodule

// ===== design/caldc_weekday.sv =====
// Three-stage weekday and flag pipeline behind the date state; last stage is the
// result register. Depends on caldc_pkg.
module caldc_weekday import caldc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_date   i_date,
    input  logic    i_rej,
    output logic    o_valid,
    output t_result o_result
);

    localparam int P100_W = YEAR_W + 13;
    localparam int Q100_W = 8;
    localparam int SUM_W  = 15;
    localparam int P7_W   = SUM_W + 16;
    localparam int Q7_W   = P7_W - RECIP7_SH;

    // stage A: March-based year/month, century count, month flags
    logic                a_early;
    logic [YEAR_W-1:0]   a_yy;
    logic [MONTH_W-1:0]  a_mm;
    logic [P100_W-1:0]   a_p100;
    logic [DAY_W-1:0]    a_dim;

    logic                r_b_valid;
    t_date               r_b_date;
    logic                r_b_rej;
    logic                r_b_mend;
    logic                r_b_dec;
    logic [YEAR_W-1:0]   r_b_yy;
    logic [Q100_W-1:0]   r_b_q100;
    logic [DAY_W-1:0]    r_b_moff;

    // stage B: weekday sum
    logic [SUM_W-1:0]    b_sum;
    logic                r_c_valid;
    t_date               r_c_date;
    logic                r_c_rej;
    logic                r_c_mend;
    logic                r_c_dec;
    logic [SUM_W-1:0]    r_c_sum;

    // stage C: sum mod 7
    logic [P7_W-1:0]     c_p7;
    logic [Q7_W-1:0]     c_q7;
    logic [SUM_W-1:0]    c_rem;
    logic [WDAY_W-1:0]   c_wd;

    logic                r_out_valid;
    t_result             r_out;

    always_comb begin
        a_early = (i_date.month <= MONTH_FEB);
        a_yy    = i_date.year - YEAR_W'(a_early);
        a_mm    = a_early ? (i_date.month + 4'd10) : (i_date.month - 4'd2);
        a_p100  = P100_W'(a_yy) * P100_W'(RECIP100);
        a_dim   = days_in(is_leap(i_date.year), i_date.month);
    end

    always_comb begin
        b_sum = SUM_W'(r_b_date.day) + SUM_W'(r_b_yy) + SUM_W'(r_b_yy >> 2)
              - SUM_W'(r_b_q100) + SUM_W'(r_b_q100 >> 2) + SUM_W'(r_b_moff);
    end

    always_comb begin
        c_p7  = P7_W'(r_c_sum) * P7_W'(RECIP7);
        c_q7  = c_p7[RECIP7_SH +: Q7_W];
        c_rem = r_c_sum - (SUM_W'(c_q7) << 3) + SUM_W'(c_q7);
        c_wd  = c_rem[WDAY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid   <= i_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_date <= i_date;
            r_b_rej  <= i_rej;
            r_b_mend <= (i_date.day == a_dim);
            r_b_dec  <= (i_date.month == MONTH_DEC);
            r_b_yy   <= a_yy;
            r_b_q100 <= a_p100[RECIP100_SH +: Q100_W];
            r_b_moff <= month_offset(a_mm);

            r_c_date <= r_b_date;
            r_c_rej  <= r_b_rej;
            r_c_mend <= r_b_mend;
            r_c_dec  <= r_b_dec;
            r_c_sum  <= b_sum;

            r_out.date      <= r_c_date;
            r_out.weekday   <= c_wd;
            r_out.weekend   <= (c_wd == WDAY_SUN) || (c_wd == WDAY_SAT);
            r_out.month_end <= r_c_mend;
            r_out.december  <= r_c_dec;
            r_out.rejected  <= r_c_rej;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== test/calendar_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the calendar date counter: watches both stream channels,
// predicts every result from its own copy of the date, and compares in order.
// Depends on caldc_pkg for field widths, request modes and the reset date.
module calendar_checker import caldc_pkg::*; #(
    parameter int YEAR_MAX = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // load_year[13:0], load_month[17:14], load_day[22:18], 0
    input  logic [1:0]  i_s_tuser,   // mode[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // year, month, day, weekday, weekend, month_end,
                                     // december, rejected, 0 (lowest first)
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic               weekend;
        logic               month_end;
        logic               december;
        logic               rejected;
    } t_day_report;

    t_day_report        expected_days[$];
    logic [YEAR_W-1:0]  cal_year  = RESET_YEAR;
    logic [MONTH_W-1:0] cal_month = MONTH_JAN;
    logic [DAY_W-1:0]   cal_day   = DAY_FIRST;
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic int month_length(int y, int m);
        if (m < 1 || m > 12) return 0;
        if (m == 2) return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // March-based weekday sum; January and February belong to the year before.
    function automatic int weekday_of(int y, int m, int d);
        int shift;
        int yy;
        int mm;
        shift = (m <= 2) ? 1 : 0;
        yy    = y - shift;
        mm    = m + 12 * shift - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    // Apply one request to the tracked date and return the result it must produce.
    function automatic t_day_report step_calendar(logic [MODE_W-1:0] mode,
                                                  int ly, int lm, int ld);
        t_day_report r;
        int y;
        int m;
        int d;
        int wd;
        logic rej;
        y   = cal_year;
        m   = cal_month;
        d   = cal_day;
        rej = 1'b0;
        case (mode)
            MODE_FWD: begin
                if (d < month_length(y, m)) d++;
                else if (m < 12) begin
                    d = 1;
                    m++;
                end else if (y >= YEAR_MAX) rej = 1'b1;
                else begin
                    d = 1;
                    m = 1;
                    y++;
                end
            end
            MODE_BACK: begin
                if (d > 1) d--;
                else if (m > 1) begin
                    m--;
                    d = month_length(y, m);
                end else if (y <= 1) rej = 1'b1;
                else begin
                    y--;
                    m = 12;
                    d = 31;
                end
            end
            MODE_LOAD: begin
                if (ly >= 1 && ly <= YEAR_MAX && lm >= 1 && lm <= 12 &&
                        ld >= 1 && ld <= month_length(ly, lm)) begin
                    y = ly;
                    m = lm;
                    d = ld;
                end else rej = 1'b1;
            end
            default: ;   // hold: keep the date, no rejection
        endcase
        cal_year    = y;
        cal_month   = m;
        cal_day     = d;
        wd          = weekday_of(y, m, d);
        r.year      = y;
        r.month     = m;
        r.day       = d;
        r.weekday   = wd;
        r.weekend   = (wd == WDAY_SUN || wd == WDAY_SAT);
        r.month_end = (d == month_length(y, m));
        r.december  = (m == 12);
        r.rejected  = rej;
        return r;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_day_report want;
        if (!i_rst_n) begin
            cal_year  = RESET_YEAR;
            cal_month = MONTH_JAN;
            cal_day   = DAY_FIRST;
            expected_days.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_days.size() == 0) begin
                    fail_count++;
                    $error("result: expected none, actual %0h", i_m_tdata);
                end else begin
                    want = expected_days.pop_front();
                    check_field("year",      want.year,      i_m_tdata[13:0]);
                    check_field("month",     want.month,     i_m_tdata[17:14]);
                    check_field("day",       want.day,       i_m_tdata[22:18]);
                    check_field("weekday",   want.weekday,   i_m_tdata[25:23]);
                    check_field("weekend",   want.weekend,   i_m_tdata[26]);
                    check_field("month_end", want.month_end, i_m_tdata[27]);
                    check_field("december",  want.december,  i_m_tdata[28]);
                    check_field("rejected",  want.rejected,  i_m_tdata[29]);
                    check_field("padding",   0,              i_m_tdata[31:30]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_days.push_back(step_calendar(i_s_tuser, i_s_tdata[13:0],
                                                      i_s_tdata[17:14], i_s_tdata[22:18]));
        end
        o_pending = expected_days.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the calendar date counter testbench: clock, reset, request stimulus,
// result-side back-pressure, watchdog and verdict. Depends on caldc_pkg,
// the calendar_date_counter block and the calendar_checker module.
module tb_top;
    import caldc_pkg::*;

    localparam int YEAR_LIMIT   = 9999;
    localparam int RANDOM_ITEMS = 1150;
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 8;      // extra wait after the last expected result
    localparam int HOLD_CYCLES  = 120;    // long receiver hold-off to fill the pipe

    logic        i_clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;   // load_year[13:0], load_month[17:14], load_day[22:18], 0
    logic [1:0]  s_tuser  = MODE_HOLD;   // mode[1:0]
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;  // year, month, day, weekday, weekend, month_end,
                                  // december, rejected, 0 (lowest first)
    int          fail_count;
    int          pending;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int sent = 0;

    calendar_date_counter #(.YEAR_MAX(YEAR_LIMIT)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    calendar_checker #(.YEAR_MAX(YEAR_LIMIT)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request, idling first at the current rate, and hold it until taken.
    // Called at a rising edge; returns at the edge where the request was accepted.
    task automatic send_item(logic [MODE_W-1:0] mode, int y, int m, int d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, d[DAY_W-1:0], m[MONTH_W-1:0], y[YEAR_W-1:0]};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    // Step and hold requests carry random load fields; the block must ignore them.
    task automatic send_step(logic [MODE_W-1:0] mode);
        send_item(mode, $urandom_range(16383), $urandom_range(15), $urandom_range(31));
    endtask

    // Load a date near a boundary: year limits, centuries, leap years, month ends.
    task automatic load_edge_date();
        int y;
        int m;
        int d;
        case ($urandom_range(8))
            0:       y = 1;
            1:       y = $urandom_range(1, 3);
            2:       y = 100 * $urandom_range(1, 99);
            3:       y = 400 * $urandom_range(1, 24);
            4:       y = YEAR_LIMIT;
            5:       y = YEAR_LIMIT - 1;
            6:       y = 4 * $urandom_range(1, YEAR_LIMIT / 4);
            default: y = $urandom_range(1, YEAR_LIMIT);
        endcase
        case ($urandom_range(5))
            0:       m = MONTH_JAN;
            1:       m = MONTH_FEB;
            2:       m = MONTH_DEC;
            default: m = $urandom_range(1, 12);
        endcase
        case ($urandom_range(5))
            0:       d = 1;
            1:       d = 28;
            2:       d = 29;
            3:       d = 30;
            4:       d = 31;
            default: d = $urandom_range(1, 28);
        endcase
        send_item(MODE_LOAD, y, m, d);
    endtask

    // Walk the date mostly one way so runs cross month and year boundaries.
    task automatic walk_days(int count);
        logic [MODE_W-1:0] dir;
        int pick;
        dir = $urandom_range(1) ? MODE_BACK : MODE_FWD;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 85)      send_step(dir);
            else if (pick < 95) send_step(dir == MODE_FWD ? MODE_BACK : MODE_FWD);
            else                send_step(MODE_HOLD);
        end
    endtask

    // Receiver: stall at the current rate, and twice hold off for a long stretch
    // while the sender keeps offering, so the pipe fills and tready drops.
    initial begin : sink
        int seen;
        int hold_left;
        seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && m_tready) seen++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (o_m_axis_tvalid && m_tready && (seen == 150 || seen == 600)) begin
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Watchdog: end the run when neither side moves a request for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int target;
        int directed;
        int pick;

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset date of 1 January 2000.
        send_step(MODE_FWD);
        send_step(MODE_BACK);
        send_step(MODE_BACK);                    // back across the year into 1999
        send_step(MODE_HOLD);
        send_item(MODE_LOAD, 2000, 2, 28);       // century leap year
        send_step(MODE_FWD);
        send_step(MODE_FWD);
        send_step(MODE_BACK);
        send_item(MODE_LOAD, 1900, 2, 28);       // century without leap day
        send_step(MODE_FWD);
        send_item(MODE_LOAD, 2023, 2, 29);       // no leap day: refuse
        send_item(MODE_LOAD, 2024, 2, 29);
        send_item(MODE_LOAD, 2023, 4, 30);
        send_step(MODE_FWD);
        send_item(MODE_LOAD, YEAR_LIMIT, 12, 31);
        send_step(MODE_FWD);                     // upper limit: hold and flag
        send_step(MODE_BACK);
        send_item(MODE_LOAD, 1, 1, 1);
        send_step(MODE_BACK);                    // lower limit: hold and flag
        send_step(MODE_FWD);
        send_item(MODE_LOAD, 0, 6, 15);          // invalid loads from here on
        send_item(MODE_LOAD, YEAR_LIMIT + 1, 6, 15);
        send_item(MODE_LOAD, 2000, 0, 10);
        send_item(MODE_LOAD, 2000, 13, 10);
        send_item(MODE_LOAD, 2000, 6, 0);
        send_item(MODE_LOAD, 16383, 15, 31);
        directed = sent;

        // Random part in four idling phases: none, sender, receiver, both.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
                default: begin src_idle_pct = 18; snk_stall_pct = 18; end
            endcase
            target = directed + (phase + 1) * RANDOM_ITEMS / 4;
            while (sent < target) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    load_edge_date();
                    walk_days($urandom_range(1, 40));
                end else if (pick < 90) begin
                    walk_days($urandom_range(1, 8));
                end else if (pick < 97) begin
                    // noise load: any field value at all
                    send_item(MODE_LOAD, $urandom_range(16383), $urandom_range(15),
                              $urandom_range(31));
                end else begin
                    send_item(MODE_LOAD, $urandom_range(1, YEAR_LIMIT),
                              $urandom_range(1, 12), $urandom_range(1, 28));
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain: step past the last request so it is counted, wait for every
        // expected result, then wait out the drain margin.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/caldc_pkg.sv
design/caldc_date_step.sv
design/caldc_weekday.sv
design/calendar_date_counter.sv
test/calendar_checker.sv
test/tb_top.sv
